[rtl/core/arp_probe_verify_scheduler_macros.svh]
// Assertion macros for the ARP probe scheduler.
// Used by the modules that carry concurrent assertions; no other dependencies.
`ifndef ARP_PROBE_VERIFY_SCHEDULER_MACROS_SVH
`define ARP_PROBE_VERIFY_SCHEDULER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define APV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define APV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/apvs_pkg.sv]
// Shared types and constants of the ARP probe scheduler.
// No dependencies.
package apvs_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] FUNC_ADD    = 3'd0;
    localparam logic [2:0] FUNC_REMOVE = 3'd1;
    localparam logic [2:0] FUNC_TICK   = 3'd2;
    localparam logic [2:0] FUNC_ROUND  = 3'd3;
    localparam logic [2:0] FUNC_SEND   = 3'd4;
    localparam logic [2:0] FUNC_CLEAR  = 3'd5;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_PROBE  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [1:0] RS_PROGRESS = 2'd0;
    localparam logic [1:0] RS_COMPLETE = 2'd1;
    localparam logic [1:0] RS_FAILURE  = 2'd2;
    localparam logic [1:0] RS_BUSY     = 2'd3;

    localparam logic [1:0] ST_SENT  = 2'd0;
    localparam logic [1:0] ST_NOBUF = 2'd1;

    localparam logic [1:0] REG_PROBE_COUNT = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] REG_WAIT_MIN    = 2'd2;
    localparam logic [1:0] REG_WAIT_MAX    = 2'd3;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    // One table entry as held by a cell.
    typedef struct packed {
        logic        used;
        logic [31:0] ip;
        logic        tent;
        logic        dup;
        logic [3:0]  att;
        logic [3:0]  err;
    } t_entry;

    // Operation broadcast from the controller to every cell.
    typedef enum logic [2:0] {
        OP_NONE, OP_APPEND, OP_SHIFT, OP_CLEAR, OP_PROMOTE, OP_OUTCOME
    } t_cell_op;

    typedef struct packed {
        t_cell_op    op;
        logic [IDX_W-1:0] idx;
        logic [31:0] ip;
        logic        tent;
        logic [1:0]  status;
        logic [3:0]  probe_count;
        logic [3:0]  retry_limit;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_EMIT, S_DIV, S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  entry_count;
        logic        removed;
        logic [31:0] probe_ip;
        logic [1:0]  round_status;
        logic [15:0] timeout_ms;
        logic        last;
    } t_result;

endpackage

[rtl/core/apvs_if.sv]
// Valid/ready channel interfaces of the ARP probe scheduler.
// Depends on nothing but the clockless payload definitions below.
interface apvs_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] address_ip;
    logic        start_tentative;
    logic [1:0]  send_status;
    modport source(output valid, func, address_ip, start_tentative, send_status, input ready);
    modport sink(input valid, func, address_ip, start_tentative, send_status, output ready);
endinterface

interface apvs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  entry_count;
    logic        removed;
    logic [31:0] probe_ip;
    logic [1:0]  round_status;
    logic [15:0] timeout_ms;
    logic        last;
    modport source(output valid, kind, entry_count, removed, probe_ip, round_status,
                   timeout_ms, last, input ready);
    modport sink(input valid, kind, entry_count, removed, probe_ip, round_status,
                 timeout_ms, last, output ready);
endinterface

[rtl/core/apvs_cell.sv]
// One table slot of the ARP probe scheduler; cells form a shifting row.
// Depends on apvs_pkg.
module apvs_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  apvs_pkg::t_cell_cmd i_cmd,
    input  logic [apvs_pkg::IDX_W-1:0] i_my_idx,
    input  apvs_pkg::t_entry   i_next,
    output apvs_pkg::t_entry   o_entry
);
    import apvs_pkg::*;

    t_entry r_e, n_e;
    logic [3:0] w_err_inc;

    assign o_entry = r_e;
    assign w_err_inc = (r_e.err == 4'd15) ? r_e.err : r_e.err + 4'd1;

    always_comb begin
        n_e = r_e;
        unique case (i_cmd.op)
            OP_APPEND: begin
                if (i_cmd.idx == i_my_idx) begin
                    n_e.used = 1'b1;
                    n_e.ip   = i_cmd.ip;
                    n_e.tent = i_cmd.tent;
                    n_e.dup  = 1'b0;
                    n_e.att  = 4'd0;
                    n_e.err  = 4'd0;
                end
            end
            OP_SHIFT: begin
                // Cells at and above the removed slot take their upper neighbour.
                if (i_my_idx >= i_cmd.idx) begin
                    n_e = i_next;
                end
            end
            OP_CLEAR: begin
                n_e.used = 1'b0;
                n_e.tent = 1'b0;
                n_e.dup  = 1'b0;
                n_e.att  = 4'd0;
                n_e.err  = 4'd0;
            end
            OP_PROMOTE: begin
                if (r_e.used && !r_e.dup && r_e.tent && r_e.att >= i_cmd.probe_count) begin
                    n_e.tent = 1'b0;
                end
            end
            OP_OUTCOME: begin
                if (i_cmd.idx == i_my_idx) begin
                    if (i_cmd.status == ST_SENT) begin
                        if (r_e.att != 4'd15) n_e.att = r_e.att + 4'd1;
                    end else if (i_cmd.status == ST_NOBUF) begin
                        n_e.err = w_err_inc;
                        if (w_err_inc >= i_cmd.retry_limit) n_e.dup = 1'b1;
                    end else begin
                        n_e.dup = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.used <= 1'b0;
            r_e.tent <= 1'b0;
            r_e.dup  <= 1'b0;
            r_e.att  <= 4'd0;
            r_e.err  <= 4'd0;
            r_e.ip   <= n_e.ip;
        end else begin
            r_e <= n_e;
        end
    end
endmodule

[rtl/core/apvs_mod.sv]
// Bit-serial remainder unit: lfsr mod span, one quotient bit a cycle.
// Depends on apvs_pkg.
module apvs_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [16:0] o_rem
);
    import apvs_pkg::*;

    logic [16:0] r_rem, n_rem;
    logic [15:0] r_num;
    logic [16:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [17:0] w_trial;

    assign w_trial = {r_rem, r_num[15]};
    assign n_rem = (w_trial >= {1'b0, r_den}) ? 17'(w_trial - {1'b0, r_den}) : w_trial[16:0];
    assign o_done = r_busy && (r_cnt == 5'd16);
    assign o_rem = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd0;
        end else if (r_busy && r_cnt != 5'd16) begin
            r_cnt <= r_cnt + 5'd1;
        end else begin
            r_busy <= 1'b0;
        end
        if (i_start) begin
            r_rem <= 17'd0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy && r_cnt != 5'd16) begin
            r_rem <= n_rem;
            r_num <= {r_num[14:0], 1'b0};
        end
    end
endmodule

[rtl/core/arp_probe_verify_scheduler.sv]
// Channel   | Dir | Payload
// s_in      | in  | func, address_ip, start_tentative, send_status
// m_out     | out | kind, entry_count, removed, probe_ip, round_status, timeout_ms, last
// apb       | in  | probe_count, retry_limit, wait_min_ms, wait_max_ms
// A tick, a clear or an outcome that is not the last is handled in the idle state; an
// add or a remove walks the row before its answer is offered. A round walks the row to
// give its probe requests; a round with none, and the last outcome, walk it again for
// the status, and a progress status whose wait_max exceeds wait_min then waits for the
// bit-serial remainder of the wait draw.
// Reset is synchronous and active low; a stalled output holds the result and the walk.
// Top level: controller over a row of apvs_cell and the apvs_mod remainder unit.
module arp_probe_verify_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    apvs_in_if.sink     s_in,
    apvs_out_if.source  m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import apvs_pkg::*;
    `include "arp_probe_verify_scheduler_macros.svh"

    logic [3:0]  r_probe_count, r_retry_limit;
    logic [15:0] r_wait_min, r_wait_max;
    logic [1:0]  w_reg;

    assign pready = 1'b1;
    assign w_reg = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_count <= 4'd3;
            r_retry_limit <= 4'd3;
            r_wait_min    <= 16'd1000;
            r_wait_max    <= 16'd2000;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_PROBE_COUNT: r_probe_count <= pwdata[3:0];
                REG_RETRY_LIMIT: r_retry_limit <= pwdata[3:0];
                REG_WAIT_MIN:    r_wait_min    <= pwdata[15:0];
                REG_WAIT_MAX:    r_wait_max    <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_PROBE_COUNT: prdata = {28'd0, r_probe_count};
            REG_RETRY_LIMIT: prdata = {28'd0, r_retry_limit};
            REG_WAIT_MIN:    prdata = {16'd0, r_wait_min};
            REG_WAIT_MAX:    prdata = {16'd0, r_wait_max};
        endcase
    end

    // Cell row
    t_cell_cmd w_cmd;
    t_entry    w_ent  [TABLE_DEPTH];
    t_entry    w_next [TABLE_DEPTH];

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            if (g == TABLE_DEPTH - 1) begin : g_top
                assign w_next[g] = '0;
            end else begin : g_mid
                assign w_next[g] = w_ent[g+1];
            end
            apvs_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_my_idx(IDX_W'(g)),
                .i_next  (w_next[g]),
                .o_entry (w_ent[g])
            );
        end
    endgenerate

    // Controller state
    t_state r_state, n_state;
    logic [2:0]  r_func;
    logic [31:0] r_ip;
    logic        r_tent;
    logic [1:0]  r_st;
    logic [CNT_W-1:0] r_used, n_used;
    logic [15:0] r_remaining, n_remaining;
    logic [15:0] r_lfsr, n_lfsr;
    logic [CNT_W-1:0] r_pend_cnt, n_pend_cnt;
    logic [TABLE_DEPTH-1:0] r_pend_mask, n_pend_mask;
    logic        r_wait, n_wait;
    logic [CNT_W-1:0] r_scan, n_scan;
    logic        r_found, n_found;
    logic [IDX_W-1:0] r_fidx, n_fidx;
    logic        r_any_att, n_any_att;
    t_result     r_res, n_res;
    logic        r_ovalid, n_ovalid;
    logic        w_mod_start, w_mod_done;
    logic [16:0] w_mod_rem;
    logic [IDX_W-1:0] w_sidx;
    logic [IDX_W-1:0] w_low_idx;
    logic        w_low_found;
    logic [TABLE_DEPTH-1:0] w_low_mask, w_high_mask;

    assign w_sidx = r_scan[IDX_W-1:0];

    // The remainder is taken of the freshly stepped LFSR value.
    apvs_mod u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_mod_start),
        .i_num  (n_lfsr),
        .i_den  (17'({1'b0, r_wait_max} - {1'b0, r_wait_min} + 17'd1)),
        .o_done (w_mod_done),
        .o_rem  (w_mod_rem)
    );

    // Lowest pending entry, a short priority search over the mask.
    always_comb begin
        w_low_idx = '0;
        w_low_found = 1'b0;
        for (int j = TABLE_DEPTH - 1; j >= 0; j--) begin
            if (r_pend_mask[j]) begin
                w_low_idx = IDX_W'(j);
                w_low_found = 1'b1;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            w_low_mask[j]  = (j < int'(r_fidx));
            w_high_mask[j] = (j > int'(r_fidx));
        end
    end

    assign s_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign m_out.valid        = r_ovalid;
    assign m_out.kind         = r_res.kind;
    assign m_out.entry_count  = r_res.entry_count;
    assign m_out.removed      = r_res.removed;
    assign m_out.probe_ip     = r_res.probe_ip;
    assign m_out.round_status = r_res.round_status;
    assign m_out.timeout_ms   = r_res.timeout_ms;
    assign m_out.last         = r_res.last;

    always_comb begin
        n_state = r_state;
        n_used = r_used;
        n_remaining = r_remaining;
        n_lfsr = r_lfsr;
        n_pend_cnt = r_pend_cnt;
        n_pend_mask = r_pend_mask;
        n_wait = r_wait;
        n_scan = r_scan;
        n_found = r_found;
        n_fidx = r_fidx;
        n_any_att = r_any_att;
        n_res = r_res;
        n_ovalid = r_ovalid;
        w_mod_start = 1'b0;
        w_cmd = '0;
        w_cmd.op = OP_NONE;
        w_cmd.ip = r_ip;
        w_cmd.tent = r_tent;
        w_cmd.status = r_st;
        w_cmd.probe_count = r_probe_count;
        w_cmd.retry_limit = r_retry_limit;
        if (m_out.valid && m_out.ready) n_ovalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_in.valid && s_in.ready) begin
                    n_scan = '0;
                    n_found = 1'b0;
                    n_any_att = 1'b0;
                    n_fidx = '0;
                    unique case (s_in.func)
                        FUNC_ADD, FUNC_REMOVE: n_state = S_SCAN;
                        FUNC_TICK: begin
                            if (r_remaining != 16'd0) n_remaining = r_remaining - 16'd1;
                        end
                        FUNC_ROUND: begin
                            n_res = '0;
                            n_res.kind = KIND_STATUS;
                            n_res.last = 1'b1;
                            if (r_pend_cnt != '0) begin
                                n_res.round_status = RS_BUSY;
                                n_ovalid = 1'b1;
                            end else if (r_remaining != 16'd0) begin
                                n_res.round_status = RS_PROGRESS;
                                n_res.timeout_ms = r_remaining;
                                n_ovalid = 1'b1;
                            end else begin
                                w_cmd.op = OP_PROMOTE;
                                n_wait = 1'b0;
                                n_state = S_EMIT;
                            end
                        end
                        FUNC_SEND: begin
                            if (r_pend_cnt != '0 && w_low_found) begin
                                w_cmd.op = OP_OUTCOME;
                                w_cmd.idx = w_low_idx;
                                w_cmd.status = s_in.send_status;
                                n_pend_mask[w_low_idx] = 1'b0;
                                n_pend_cnt = r_pend_cnt - CNT_W'(1);
                                if (s_in.send_status == ST_SENT) n_wait = 1'b1;
                                else if (s_in.send_status == ST_NOBUF &&
                                         ((w_ent[w_low_idx].err == 4'd15 ? 4'd15 :
                                           w_ent[w_low_idx].err + 4'd1) < r_retry_limit))
                                    n_wait = 1'b1;
                                if (r_pend_cnt == CNT_W'(1)) n_state = S_SCAN;
                            end
                        end
                        FUNC_CLEAR: begin
                            w_cmd.op = OP_CLEAR;
                            n_used = '0;
                            n_remaining = '0;
                            n_pend_cnt = '0;
                            n_pend_mask = '0;
                            n_wait = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // Walk the cells one a cycle: match search or attempt check.
                if (r_scan < r_used) begin
                    if (!r_found && w_ent[w_sidx].ip == r_ip) begin
                        n_found = 1'b1;
                        n_fidx = w_sidx;
                    end
                    if (w_ent[w_sidx].att != 4'd0) n_any_att = 1'b1;
                end
                if (r_scan == CNT_W'(TABLE_DEPTH)) begin
                    n_res = '0;
                    n_res.last = 1'b1;
                    n_state = S_IDLE;
                    unique case (r_func)
                        FUNC_ADD: begin
                            n_res.kind = KIND_ADD;
                            n_ovalid = 1'b1;
                            if (r_probe_count != 4'd0 && r_ip != 32'd0 && !r_found &&
                                r_used < CNT_W'(TABLE_DEPTH)) begin
                                w_cmd.op = OP_APPEND;
                                w_cmd.idx = r_used[IDX_W-1:0];
                                n_used = r_used + CNT_W'(1);
                                n_res.entry_count = 4'(r_used + CNT_W'(1));
                            end
                        end
                        FUNC_REMOVE: begin
                            n_res.kind = KIND_REMOVE;
                            n_ovalid = 1'b1;
                            if (r_ip != 32'd0 && r_found) begin
                                w_cmd.op = OP_SHIFT;
                                w_cmd.idx = r_fidx;
                                n_res.removed = 1'b1;
                                n_used = r_used - CNT_W'(1);
                                if (r_pend_mask[r_fidx]) n_pend_cnt = r_pend_cnt - CNT_W'(1);
                                n_pend_mask = (r_pend_mask & w_low_mask) |
                                              ((r_pend_mask & w_high_mask) >> 1);
                                if ((r_pend_mask[r_fidx] ? r_pend_cnt - CNT_W'(1)
                                                         : r_pend_cnt) == '0)
                                    n_wait = 1'b0;
                            end
                        end
                        default: begin
                            // End of round, from a round with no probes or the last outcome.
                            n_res.kind = KIND_STATUS;
                            if (r_wait) begin
                                n_wait = 1'b0;
                                n_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_MASK : 16'd0);
                                if (r_wait_max <= r_wait_min) begin
                                    n_remaining = r_wait_min;
                                    n_res.timeout_ms = r_wait_min;
                                    n_ovalid = 1'b1;
                                end else begin
                                    w_mod_start = 1'b1;
                                    n_state = S_DIV;
                                end
                            end else begin
                                n_res.round_status = (r_any_att || (r_scan < r_used &&
                                    w_ent[w_sidx].att != 4'd0)) ? RS_COMPLETE : RS_FAILURE;
                                n_ovalid = 1'b1;
                            end
                        end
                    endcase
                end else begin
                    n_scan = r_scan + CNT_W'(1);
                end
            end
            S_EMIT: begin
                if (!r_ovalid || (m_out.valid && m_out.ready)) begin
                    if (r_scan == CNT_W'(TABLE_DEPTH)) begin
                        if (r_pend_cnt == '0) begin
                            n_scan = '0;
                            n_state = S_SCAN;
                        end else begin
                            n_res = '0;
                            n_res.kind = KIND_STATUS;
                            n_res.round_status = RS_BUSY;
                            n_res.last = 1'b1;
                            n_ovalid = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_scan = r_scan + CNT_W'(1);
                        if (r_scan < r_used && !w_ent[w_sidx].dup && w_ent[w_sidx].tent) begin
                            n_pend_mask[w_sidx] = 1'b1;
                            n_pend_cnt = r_pend_cnt + CNT_W'(1);
                            n_res = '0;
                            n_res.kind = KIND_PROBE;
                            n_res.probe_ip = w_ent[w_sidx].ip;
                            n_ovalid = 1'b1;
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_mod_done) begin
                    n_remaining = r_wait_min + w_mod_rem[15:0];
                    n_res.timeout_ms = r_wait_min + w_mod_rem[15:0];
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_remaining <= '0;
            r_lfsr <= LFSR_SEED;
            r_pend_cnt <= '0;
            r_pend_mask <= '0;
            r_wait <= 1'b0;
            r_ovalid <= 1'b0;
            r_scan <= '0;
            r_found <= 1'b0;
            r_any_att <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used <= n_used;
            r_remaining <= n_remaining;
            r_lfsr <= n_lfsr;
            r_pend_cnt <= n_pend_cnt;
            r_pend_mask <= n_pend_mask;
            r_wait <= n_wait;
            r_ovalid <= n_ovalid;
            r_scan <= n_scan;
            r_found <= n_found;
            r_any_att <= n_any_att;
        end
        r_fidx <= n_fidx;
        r_res <= n_res;
        if (s_in.valid && s_in.ready) begin
            r_func <= s_in.func;
            r_ip <= s_in.address_ip;
            r_tent <= s_in.start_tentative;
            r_st <= s_in.send_status;
        end
    end

    `APV_ASSERT_IMPL(a_pend_cnt, i_clk, i_rst_n, 1'b1,
        r_pend_cnt == CNT_W'($countones(r_pend_mask)), "pending count and mask disagree")
    `APV_ASSERT_IMPL(a_used_range, i_clk, i_rst_n, 1'b1,
        r_used <= CNT_W'(TABLE_DEPTH), "table fill beyond depth")
    `APV_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_out.valid && !m_out.ready,
        m_out.valid && $stable(r_res), "result changed while stalled")
    `APV_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE,
        !s_in.ready, "input taken while busy")
endmodule

[tb/tb_top.sv]
// Self-checking bench for the ARP probe scheduler: directed and random stimulus,
// a scheduler model in a scoreboard class. Depends on apvs_pkg, apvs_if and the RTL.
module tb_top;
    import apvs_pkg::*;

    // Model of the probe table; expected results queue up in arrival order.
    class probe_table_model;
        logic [3:0]  probe_count, retry_limit;
        logic [15:0] wait_min, wait_max;
        logic [31:0] ip [TABLE_DEPTH];
        bit          tent [TABLE_DEPTH];
        bit          dup [TABLE_DEPTH];
        logic [3:0]  att [TABLE_DEPTH];
        logic [3:0]  err [TABLE_DEPTH];
        int          used;
        logic [15:0] remaining, lfsr;
        int          pending;
        logic [TABLE_DEPTH-1:0] pmask;
        bit          wait_needed;
        t_result     expected_results[$];
        int          mismatches;

        function new();
            probe_count = 3; retry_limit = 3; wait_min = 1000; wait_max = 2000;
            lfsr = LFSR_SEED;
            wipe();
            mismatches = 0;
        endfunction

        function void wipe();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                ip[i] = 0; tent[i] = 0; dup[i] = 0; att[i] = 0; err[i] = 0;
            end
            used = 0; remaining = 0; pending = 0; pmask = 0; wait_needed = 0;
        endfunction

        function void push(logic [1:0] k, logic [3:0] c, logic r, logic [31:0] p,
                           logic [1:0] s, logic [15:0] t, logic l);
            t_result e;
            e.kind = k; e.entry_count = c; e.removed = r; e.probe_ip = p;
            e.round_status = s; e.timeout_ms = t; e.last = l;
            expected_results.push_back(e);
        endfunction

        function int find(logic [31:0] a);
            for (int i = 0; i < used; i++)
                if (ip[i] == a) return i;
            return -1;
        endfunction

        function void end_round();
            bit any;
            if (wait_needed) begin
                wait_needed = 0;
                lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
                if (wait_max <= wait_min) remaining = wait_min;
                else remaining = wait_min + 16'(32'(lfsr) % (32'(wait_max) - wait_min + 1));
                push(KIND_STATUS, 0, 0, 0, RS_PROGRESS, remaining, 1);
                return;
            end
            any = 0;
            for (int i = 0; i < used; i++)
                if (att[i] > 0) any = 1;
            push(KIND_STATUS, 0, 0, 0, any ? RS_COMPLETE : RS_FAILURE, 0, 1);
        endfunction

        function void note_input(logic [2:0] f, logic [31:0] a, logic t, logic [1:0] s);
            int i, n;
            case (f)
                FUNC_ADD: begin
                    if (probe_count == 0 || a == 0 || find(a) >= 0 || used >= TABLE_DEPTH) begin
                        push(KIND_ADD, 0, 0, 0, 0, 0, 1);
                    end else begin
                        ip[used] = a; tent[used] = t; dup[used] = 0;
                        att[used] = 0; err[used] = 0;
                        used++;
                        push(KIND_ADD, 4'(used), 0, 0, 0, 0, 1);
                    end
                end
                FUNC_REMOVE: begin
                    i = (a == 0) ? -1 : find(a);
                    if (i < 0) begin
                        push(KIND_REMOVE, 0, 0, 0, 0, 0, 1);
                    end else begin
                        if (pmask[i]) pending--;
                        for (int j = i; j < TABLE_DEPTH - 1; j++) pmask[j] = pmask[j+1];
                        pmask[TABLE_DEPTH-1] = 0;
                        for (int j = i; j + 1 < used; j++) begin
                            ip[j] = ip[j+1]; tent[j] = tent[j+1]; dup[j] = dup[j+1];
                            att[j] = att[j+1]; err[j] = err[j+1];
                        end
                        used--;
                        ip[used] = 0; tent[used] = 0; dup[used] = 0; att[used] = 0; err[used] = 0;
                        if (pending == 0) wait_needed = 0;
                        push(KIND_REMOVE, 0, 1, 0, 0, 0, 1);
                    end
                end
                FUNC_TICK: if (remaining > 0) remaining--;
                FUNC_ROUND: begin
                    if (pending != 0) push(KIND_STATUS, 0, 0, 0, RS_BUSY, 0, 1);
                    else if (remaining != 0) push(KIND_STATUS, 0, 0, 0, RS_PROGRESS, remaining, 1);
                    else begin
                        for (int j = 0; j < used; j++)
                            if (!dup[j] && tent[j] && att[j] >= probe_count) tent[j] = 0;
                        wait_needed = 0;
                        n = 0;
                        for (int j = 0; j < used; j++) begin
                            if (dup[j] || !tent[j]) continue;
                            pmask[j] = 1; pending++; n++;
                            push(KIND_PROBE, 0, 0, ip[j], 0, 0, 0);
                        end
                        if (n == 0) end_round();
                        else push(KIND_STATUS, 0, 0, 0, RS_BUSY, 0, 1);
                    end
                end
                FUNC_SEND: begin
                    if (pending != 0 && pmask != 0) begin
                        i = 0;
                        while (!pmask[i]) i++;
                        pmask[i] = 0; pending--;
                        if (s == ST_SENT) begin
                            if (att[i] < 15) att[i]++;
                            wait_needed = 1;
                        end else if (s == ST_NOBUF) begin
                            if (err[i] < 15) err[i]++;
                            if (err[i] >= retry_limit) dup[i] = 1;
                            else wait_needed = 1;
                        end else begin
                            dup[i] = 1;
                        end
                        if (pending == 0) end_round();
                    end
                end
                FUNC_CLEAR: wipe();
                default: ;
            endcase
        endfunction

        function void check_result(t_result r);
            t_result e;
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction kind=%0d", r.kind);
                mismatches++;
                return;
            end
            e = expected_results.pop_front();
            if (r.kind != e.kind) begin
                $error("kind exp %0d got %0d", e.kind, r.kind); mismatches++;
            end
            if (r.entry_count != e.entry_count) begin
                $error("entry_count exp %0d got %0d", e.entry_count, r.entry_count); mismatches++;
            end
            if (r.removed != e.removed) begin
                $error("removed exp %0d got %0d", e.removed, r.removed); mismatches++;
            end
            if (r.probe_ip != e.probe_ip) begin
                $error("probe_ip exp %h got %h", e.probe_ip, r.probe_ip); mismatches++;
            end
            if (r.round_status != e.round_status) begin
                $error("round_status exp %0d got %0d", e.round_status, r.round_status);
                mismatches++;
            end
            if (r.timeout_ms != e.timeout_ms) begin
                $error("timeout_ms exp %0d got %0d", e.timeout_ms, r.timeout_ms); mismatches++;
            end
            if (r.last != e.last) begin
                $error("last exp %0d got %0d", e.last, r.last); mismatches++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    int          cycle_count;
    logic [31:0] addr_pool [12];

    apvs_in_if  in_ch();
    apvs_out_if out_ch();
    probe_table_model sched;

    arp_probe_verify_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(in_ch.sink), .m_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 600000) begin
                $display("arp_probe_verify_scheduler test failed");
                $finish;
            end
        end
    end

    // Result side: random stalls, compare on every accepted transaction.
    initial begin
        int gap;
        out_ch.ready <= 0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                t_result r;
                r.kind = out_ch.kind; r.entry_count = out_ch.entry_count;
                r.removed = out_ch.removed; r.probe_ip = out_ch.probe_ip;
                r.round_status = out_ch.round_status; r.timeout_ms = out_ch.timeout_ms;
                r.last = out_ch.last;
                sched.check_result(r);
            end
            if (out_ch.ready && !out_ch.valid) begin
                // Hold ready while nothing is offered.
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
                if (gap > 0 && i_rst_n) begin
                    out_ch.ready <= 0;
                    repeat (gap) @(posedge i_clk);
                end
                out_ch.ready <= 1;
            end
        end
    end

    // Valid stays up after an accept until the next transaction or an idle gap
    // replaces it within the same time step.
    task automatic send_item(logic [2:0] f, logic [31:0] a, logic t, logic [1:0] s);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1; in_ch.func <= f; in_ch.address_ip <= a;
        in_ch.start_tentative <= t; in_ch.send_status <= s;
        do @(posedge i_clk); while (!in_ch.ready);
        sched.note_input(f, a, t, s);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (sched.expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
        case (idx)
            REG_PROBE_COUNT: sched.probe_count = v[3:0];
            REG_RETRY_LIMIT: sched.retry_limit = v[3:0];
            REG_WAIT_MIN:    sched.wait_min = v;
            default:         sched.wait_max = v;
        endcase
    endtask

    task automatic set_all(logic [3:0] pc, logic [3:0] rl, logic [15:0] mn, logic [15:0] mx);
        write_reg(REG_PROBE_COUNT, 16'(pc));
        write_reg(REG_RETRY_LIMIT, 16'(rl));
        write_reg(REG_WAIT_MIN, mn);
        write_reg(REG_WAIT_MAX, mx);
    endtask

    task automatic random_item(int weight_ticks);
        int sel;
        logic [31:0] a;
        sel = $urandom_range(0, 99);
        a = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 11)];
        if (sel < 22)
            send_item(FUNC_ADD, a, $urandom_range(0, 5) != 0, 2'($urandom));
        else if (sel < 30)
            send_item(FUNC_REMOVE, a, 1'($urandom), 2'($urandom));
        else if (sel < 30 + weight_ticks)
            send_item(FUNC_TICK, $urandom, 1'($urandom), 2'($urandom));
        else if (sel < 60)
            send_item(FUNC_ROUND, $urandom, 1'($urandom), 2'($urandom));
        else if (sel < 98)
            send_item(FUNC_SEND, $urandom, 1'($urandom),
                      ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : ST_SENT);
        else if (sel < 99)
            send_item(FUNC_CLEAR, $urandom, 1'($urandom), 2'($urandom));
        else
            send_item(3'($urandom_range(6, 7)), $urandom, 1'($urandom), 2'($urandom));
    endtask

    initial begin
        sched = new();
        for (int i = 0; i < 12; i++) addr_pool[i] = $urandom | 32'h1;
        addr_pool[0] = 32'hFFFF_FFFF;
        i_rst_n <= 0;
        psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
        in_ch.valid <= 0; in_ch.func <= FUNC_TICK; in_ch.address_ip <= 0;
        in_ch.start_tentative <= 0; in_ch.send_status <= 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part at probe count 1, retry limit 2 and a wait of 0 to 3 ms, for short waits.
        set_all(4'd1, 4'd2, 16'd0, 16'd3);
        send_item(FUNC_ADD, 32'h0, 1'b1, 2'd0);
        send_item(FUNC_ADD, 32'hFFFF_FFFF, 1'b1, 2'd0);
        send_item(FUNC_ADD, 32'hFFFF_FFFF, 1'b1, 2'd0);
        send_item(FUNC_ADD, 32'h0000_0001, 1'b1, 2'd0);
        send_item(FUNC_ADD, 32'hC0A8_0001, 1'b0, 2'd0);
        send_item(FUNC_REMOVE, 32'h1234_5678, 1'b0, 2'd0);
        send_item(FUNC_REMOVE, 32'h0, 1'b0, 2'd0);
        send_item(FUNC_SEND, 32'h0, 1'b0, ST_SENT);
        send_item(FUNC_ROUND, 32'h0, 1'b0, 2'd0);
        send_item(FUNC_ROUND, 32'h0, 1'b0, 2'd0);
        send_item(FUNC_SEND, 32'h0, 1'b0, ST_SENT);
        send_item(FUNC_REMOVE, 32'h0000_0001, 1'b0, 2'd0);
        send_item(FUNC_ROUND, 32'h0, 1'b0, 2'd0);
        for (int i = 0; i < 4; i++) send_item(FUNC_TICK, 32'h0, 1'b0, 2'd0);
        send_item(FUNC_ROUND, 32'h0, 1'b0, 2'd0);
        send_item(FUNC_ADD, 32'h0A00_0002, 1'b1, 2'd0);
        send_item(FUNC_ADD, 32'h0A00_0003, 1'b1, 2'd0);
        send_item(FUNC_ROUND, 32'h0, 1'b0, 2'd0);
        send_item(FUNC_SEND, 32'h0, 1'b0, ST_NOBUF);
        send_item(FUNC_SEND, 32'h0, 1'b0, 2'd3);
        send_item(FUNC_CLEAR, 32'h0, 1'b0, 2'd0);
        send_item(3'd7, 32'hA5A5_A5A5, 1'b1, 2'd2);
        drain();

        // Random phases over several settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_all(4'd3, 4'd3, 16'd1000, 16'd2000);
                1: set_all(4'd0, 4'd0, 16'd0, 16'd0);
                2: set_all(4'd15, 4'd15, 16'd65535, 16'd65535);
                3: set_all(4'd2, 4'd1, 16'd2, 16'd5);
                4: set_all(4'd1, 4'd15, 16'd0, 16'd65535);
                default: set_all(4'($urandom_range(1, 4)), 4'($urandom_range(1, 4)),
                                 16'($urandom_range(0, 4)), 16'($urandom_range(0, 9)));
            endcase
            for (int n = 0; n < 60; n++) begin
                random_item(ph == 2 || ph == 4 ? 2 : 12);
                if (n == 30) drain();
            end
            send_item(FUNC_CLEAR, 32'h0, 1'b0, 2'd0);
            drain();
        end

        drain();
        if (sched.mismatches == 0 && sched.expected_results.size() == 0)
            $display("arp_probe_verify_scheduler test passed");
        else
            $display("arp_probe_verify_scheduler test failed");
        $finish;
    end
endmodule
